FILE: sv/usqe_pkg.sv
// shared types and constants for the quoted string escaper
`timescale 1ns / 1ps
`default_nettype none

package usqe_pkg;

    // input command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // ascii characters of the quoted text
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_U      = 7'h75;
    localparam logic [6:0] CH_N      = 7'h6E;
    localparam logic [6:0] CH_T      = 7'h74;
    localparam logic [6:0] CH_R      = 7'h72;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_HEX_A  = 7'h37;

    // utf-8 and utf-16 constants
    localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE   = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE   = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK   = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE   = 8'hF0;
    localparam logic [7:0]  CONT_MIN     = 8'h80;
    localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

    // one piece of output text within a job
    typedef enum logic [2:0] {
        UNIT_NONE = 3'd0,
        UNIT_RAW  = 3'd1,
        UNIT_ESC2 = 3'd2,
        UNIT_HEX1 = 3'd3,
        UNIT_HEX2 = 3'd4
    } unit_kind_t;

    localparam int SUB_W = 4;
    localparam logic [SUB_W-1:0] RAW_LAST  = 4'd0;
    localparam logic [SUB_W-1:0] ESC2_LAST = 4'd1;
    localparam logic [SUB_W-1:0] HEX1_LAST = 4'd5;
    localparam logic [SUB_W-1:0] HEX2_LAST = 4'd11;
    localparam logic [SUB_W-1:0] HEX_HALF  = 4'd6;

    typedef struct packed {
        unit_kind_t  kind;
        logic [15:0] first_val;
        logic [15:0] second_val;
    } unit_t;

    localparam int UNITS = 3;

    // everything one input transaction produces
    typedef struct packed {
        logic                   open_quote;
        unit_t [UNITS-1:0]      units;
        logic                   close_quote;
    } job_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

endpackage

`default_nettype wire

FILE: sv/usqe_front.sv
// front part: accepts bytes, tracks utf-8 sequences and builds jobs
`timescale 1ns / 1ps
`default_nettype none

module usqe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte
    input  logic              s_tuser,   // command
    output logic              job_push,
    output usqe_pkg::job_t    job,
    input  logic              q_full
);

    logic       open_reg, open_next;
    logic [7:0] pend_reg [3];
    logic [7:0] pend_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] seq_reg, seq_next;
    logic       accept;
    logic       job_nonempty;

    function automatic usqe_pkg::unit_t simple_unit(input logic [7:0] b);
        usqe_pkg::unit_t u;
        u = '0;
        unique case (b)
            8'h0A: begin
                u.kind = usqe_pkg::UNIT_ESC2;
                u.first_val = {9'd0, usqe_pkg::CH_N};
            end
            8'h09: begin
                u.kind = usqe_pkg::UNIT_ESC2;
                u.first_val = {9'd0, usqe_pkg::CH_T};
            end
            8'h0D: begin
                u.kind = usqe_pkg::UNIT_ESC2;
                u.first_val = {9'd0, usqe_pkg::CH_R};
            end
            8'h5C: begin
                u.kind = usqe_pkg::UNIT_ESC2;
                u.first_val = {9'd0, usqe_pkg::CH_BSLASH};
            end
            8'h22: begin
                u.kind = usqe_pkg::UNIT_ESC2;
                u.first_val = {9'd0, usqe_pkg::CH_QUOTE};
            end
            default: begin
                if (b >= 8'h20 && b <= 8'h7E) begin
                    u.kind = usqe_pkg::UNIT_RAW;
                    u.first_val = {8'd0, b};
                end
            end
        endcase
        return u;
    endfunction

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        priority if (b < usqe_pkg::CONT_MIN) begin
            n = 3'd1;
        end else if ((b & usqe_pkg::LEAD2_MASK) == usqe_pkg::LEAD2_CODE) begin
            n = 3'd2;
        end else if ((b & usqe_pkg::LEAD3_MASK) == usqe_pkg::LEAD3_CODE) begin
            n = 3'd3;
        end else if ((b & usqe_pkg::LEAD4_MASK) == usqe_pkg::LEAD4_CODE) begin
            n = 3'd4;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

    function automatic usqe_pkg::unit_t hex_byte(input logic [7:0] b);
        usqe_pkg::unit_t u;
        u = '0;
        u.kind = usqe_pkg::UNIT_HEX1;
        u.first_val = {8'd0, b};
        return u;
    endfunction

    function automatic usqe_pkg::unit_t decode(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [2:0] len);
        usqe_pkg::unit_t u;
        logic [20:0]     cp;
        logic [20:0]     off;
        u = '0;
        unique case (len)
            3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
            3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        endcase
        off = cp - usqe_pkg::SUPP_BASE;
        if (cp <= usqe_pkg::BMP_MAX) begin
            u.kind = usqe_pkg::UNIT_HEX1;
            u.first_val = cp[15:0];
        end else begin
            u.kind = usqe_pkg::UNIT_HEX2;
            u.first_val = usqe_pkg::SURR_HI_BASE + {5'd0, off[20:10]};
            u.second_val = usqe_pkg::SURR_LO_BASE + {6'd0, off[9:0]};
        end
        return u;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_comb begin
        usqe_pkg::unit_t su;
        usqe_pkg::unit_t su2;
        logic [2:0]      len;
        logic            take_b2;
        job       = '0;
        su        = '0;
        su2       = '0;
        len       = '0;
        take_b2   = 1'b1;
        open_next = open_reg;
        cnt_next  = cnt_reg;
        seq_next  = seq_reg;
        pend_next = pend_reg;
        job.open_quote = !open_reg;
        if (s_tuser == usqe_pkg::CMD_END) begin
            // end of string: flush held bytes, then the closing quote
            job.close_quote = 1'b1;
            if (cnt_reg != 2'd0) begin
                job.units[0] = hex_byte(pend_reg[0]);
            end
            if (cnt_reg >= 2'd2) begin
                su = simple_unit(pend_reg[1]);
                if (su.kind != usqe_pkg::UNIT_NONE) begin
                    job.units[1] = su;
                end else if (lead_len(pend_reg[1]) == 3'd2 && cnt_reg == 2'd3) begin
                    job.units[1] = decode(pend_reg[1], pend_reg[2], 8'd0, 8'd0, 3'd2);
                    take_b2 = 1'b0;
                end else begin
                    job.units[1] = hex_byte(pend_reg[1]);
                end
            end
            if (cnt_reg == 2'd3 && take_b2) begin
                su2 = simple_unit(pend_reg[2]);
                job.units[2] = (su2.kind != usqe_pkg::UNIT_NONE) ? su2 : hex_byte(pend_reg[2]);
            end
            open_next = 1'b0;
            cnt_next  = '0;
            seq_next  = '0;
        end else begin
            open_next = 1'b1;
            if (cnt_reg == 2'd0) begin
                su  = simple_unit(s_tdata);
                len = lead_len(s_tdata);
                if (su.kind != usqe_pkg::UNIT_NONE) begin
                    job.units[0] = su;
                end else if (len <= 3'd1) begin
                    job.units[0] = hex_byte(s_tdata);
                end else begin
                    pend_next[0] = s_tdata;
                    cnt_next     = 2'd1;
                    seq_next     = len;
                end
            end else if (({1'b0, cnt_reg} + 3'd1) == seq_reg) begin
                unique case (seq_reg)
                    3'd2: job.units[0] = decode(pend_reg[0], s_tdata, 8'd0, 8'd0, 3'd2);
                    3'd3: job.units[0] = decode(pend_reg[0], pend_reg[1], s_tdata, 8'd0, 3'd3);
                    default: job.units[0] = decode(pend_reg[0], pend_reg[1], pend_reg[2],
                                                   s_tdata, 3'd4);
                endcase
                cnt_next = '0;
                seq_next = '0;
            end else begin
                pend_next[cnt_reg] = s_tdata;
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    assign job_nonempty = job.open_quote || job.close_quote ||
                          (job.units[0].kind != usqe_pkg::UNIT_NONE);
    assign job_push     = accept && job_nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            cnt_reg  <= '0;
            seq_reg  <= '0;
        end else if (accept) begin
            open_reg <= open_next;
            cnt_reg  <= cnt_next;
            seq_reg  <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg <= pend_next;
        end
    end

    a_pending_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != 2'd0) |-> (seq_reg >= 3'd2 && seq_reg <= 3'd4 &&
                               {1'b0, cnt_reg} < seq_reg))
        else $error("held byte count does not fit sequence length");

endmodule

`default_nettype wire

FILE: sv/usqe_queue.sv
// short job queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module usqe_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  usqe_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output usqe_pkg::job_t    head,
    output logic              empty
);

    usqe_pkg::job_t                    mem_reg [usqe_pkg::QUEUE_DEPTH];
    logic [usqe_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [usqe_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [usqe_pkg::QUEUE_AW:0]       count_reg;
    logic [usqe_pkg::QUEUE_AW:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (count_reg == (usqe_pkg::QUEUE_AW + 1)'(usqe_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (usqe_pkg::QUEUE_AW + 1)'(1);
            2'b01:   count_next = count_reg - (usqe_pkg::QUEUE_AW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + (usqe_pkg::QUEUE_AW)'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + (usqe_pkg::QUEUE_AW)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (usqe_pkg::QUEUE_AW + 1)'(usqe_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: sv/usqe_back.sv
// back part: expands jobs into characters on the output stream
`timescale 1ns / 1ps
`default_nettype none

module usqe_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  usqe_pkg::job_t    q_head,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_char
    output logic              m_tlast,   // last_of_run
    output logic              m_tuser    // closes_string
);

    usqe_pkg::job_t               cur_reg, cur_next;
    logic                         cur_valid_reg, cur_valid_next;
    logic [usqe_pkg::SUB_W-1:0]   sub_reg, sub_next;
    logic                         m_valid_reg;
    logic [6:0]                   m_char_reg, ch;
    logic                         m_last_reg, last;
    logic                         m_close_reg, closes;
    usqe_pkg::job_t               src;
    logic                         src_valid;
    logic [usqe_pkg::SUB_W-1:0]   sub;
    logic                         out_free;
    logic                         step;

    function automatic logic [usqe_pkg::SUB_W-1:0] unit_last(input usqe_pkg::unit_kind_t k);
        logic [usqe_pkg::SUB_W-1:0] n;
        unique case (k)
            usqe_pkg::UNIT_ESC2: n = usqe_pkg::ESC2_LAST;
            usqe_pkg::UNIT_HEX1: n = usqe_pkg::HEX1_LAST;
            usqe_pkg::UNIT_HEX2: n = usqe_pkg::HEX2_LAST;
            default:             n = usqe_pkg::RAW_LAST;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] unit_char(input usqe_pkg::unit_t u,
                                             input logic [usqe_pkg::SUB_W-1:0] s);
        logic [usqe_pkg::SUB_W-1:0] k;
        logic [15:0]                val;
        logic [3:0]                 nib;
        logic [6:0]                 c;
        if (s >= usqe_pkg::HEX_HALF) begin
            k   = s - usqe_pkg::HEX_HALF;
            val = u.second_val;
        end else begin
            k   = s;
            val = u.first_val;
        end
        unique case (k)
            4'd2:    nib = val[15:12];
            4'd3:    nib = val[11:8];
            4'd4:    nib = val[7:4];
            default: nib = val[3:0];
        endcase
        unique case (u.kind)
            usqe_pkg::UNIT_RAW: c = u.first_val[6:0];
            usqe_pkg::UNIT_ESC2: c = (s == '0) ? usqe_pkg::CH_BSLASH : u.first_val[6:0];
            usqe_pkg::UNIT_HEX1, usqe_pkg::UNIT_HEX2: begin
                if (k == 4'd0) begin
                    c = usqe_pkg::CH_BSLASH;
                end else if (k == 4'd1) begin
                    c = usqe_pkg::CH_U;
                end else if (nib < 4'd10) begin
                    c = usqe_pkg::CH_ZERO + {3'd0, nib};
                end else begin
                    c = usqe_pkg::CH_HEX_A + {3'd0, nib};
                end
            end
            default: c = usqe_pkg::CH_QUOTE;
        endcase
        return c;
    endfunction

    assign out_free  = !m_valid_reg || m_tready;
    assign src       = cur_valid_reg ? cur_reg : q_head;
    assign src_valid = cur_valid_reg || !q_empty;
    assign sub       = cur_valid_reg ? sub_reg : '0;
    assign step      = out_free && src_valid;
    assign q_pop     = step && !cur_valid_reg;

    always_comb begin
        cur_next = src;
        sub_next = '0;
        ch       = usqe_pkg::CH_QUOTE;
        last     = 1'b0;
        closes   = 1'b0;
        if (src.open_quote) begin
            cur_next.open_quote = 1'b0;
            last = (src.units[0].kind == usqe_pkg::UNIT_NONE) && !src.close_quote;
        end else if (src.units[0].kind != usqe_pkg::UNIT_NONE) begin
            ch = unit_char(src.units[0], sub);
            if (sub == unit_last(src.units[0].kind)) begin
                cur_next.units[0] = src.units[1];
                cur_next.units[1] = src.units[2];
                cur_next.units[2] = '0;
                last = (src.units[1].kind == usqe_pkg::UNIT_NONE) && !src.close_quote;
            end else begin
                sub_next = sub + (usqe_pkg::SUB_W)'(1);
            end
        end else begin
            closes = 1'b1;
            last   = 1'b1;
        end
        cur_valid_next = step ? !last : cur_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            if (out_free) begin
                m_valid_reg <= src_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            cur_reg     <= cur_next;
            sub_reg     <= sub_next;
            m_char_reg  <= ch;
            m_last_reg  <= last;
            m_close_reg <= closes;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_close_reg;

    a_close_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[6:0] == usqe_pkg::CH_QUOTE))
        else $error("closing quote not marked last or not a quote");

    a_sub_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (sub_reg <= usqe_pkg::HEX2_LAST))
        else $error("character index past longest escape");

    a_no_pop_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop |-> (!cur_valid_reg && !q_empty)))
        else $error("queue popped while a job is in progress");

endmodule

`default_nettype wire

FILE: sv/utf8_string_quote_escaper.sv
// top level of the quoted, escaped utf-8 string emitter
// usage:
//   s_ channel: one transaction per string byte (s_tuser = 0, byte in s_tdata)
//   or an end-of-string marker (s_tuser = 1). m_ channel: one ascii character
//   of the quoted escaped text per transaction, m_tlast on the final character
//   an input transaction causes, m_tuser on the closing quote.
//   an input transaction is classified by the front part in the cycle it is
//   accepted and its job is queued (4 jobs deep); the back part spells out
//   one character per cycle while m_tready is high; a job's first character
//   passes the queue and then the output register. printable bytes give 1
//   character, simple escapes 2, \uXXXX 6, surrogate pairs 12, and an end of
//   string up to 19; the back part's output register sets the sustained rate.
//   input is taken every cycle while the queue has room, so short items flow
//   back to back with no gap.
//   reset clears the open-string flag, the held utf-8 byte count, the queue
//   and the output register. when m_tready is low the output holds and the
//   queue fills, after which s_tready drops until the back part drains.
`timescale 1ns / 1ps
`default_nettype none

module utf8_string_quote_escaper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tuser,   // command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char[6:0], zero in bit 7
    output logic       m_tlast,   // last_of_run
    output logic       m_tuser    // closes_string
);

    logic           job_push;
    usqe_pkg::job_t job;
    logic           q_full;
    logic           q_pop;
    usqe_pkg::job_t q_head;
    logic           q_empty;

    usqe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .job_push (job_push),
        .job      (job),
        .q_full   (q_full)
    );

    usqe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    usqe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
